FILE: sv/tagged_varint_record_parser_defines.svh
// Assertion macros shared by the tagged varint record parser RTL.
`ifndef TAGGED_VARINT_RECORD_PARSER_DEFINES_SVH
`define TAGGED_VARINT_RECORD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define TVRP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// The condition must never be true at a clock edge outside reset.
`define TVRP_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TVRP_ASSERT(name, clk, rstn, prop)
`define TVRP_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

FILE: sv/tvrp_pkg.sv
// Package with the shared types and constants of the tagged varint record parser.
`timescale 1ns / 1ps
`default_nettype none

package tvrp_pkg;

  localparam int unsigned LenW       = 27;
  localparam int unsigned TagW       = 31;
  localparam int unsigned ValW       = 32;
  localparam int unsigned ErrW       = 3;
  localparam int unsigned KindW      = 2;
  localparam int unsigned InTdataW   = 8;
  localparam int unsigned OutTdataW  = 112;
  localparam int unsigned MaxGroups  = 5;

  localparam logic [LenW-1:0] MaxRecordReset = LenW'(64 * 1024 * 1024);

  // Result kinds.
  localparam logic [KindW-1:0] KindVarint  = 2'd0;
  localparam logic [KindW-1:0] KindHeader  = 2'd1;
  localparam logic [KindW-1:0] KindPayload = 2'd2;
  localparam logic [KindW-1:0] KindClose   = 2'd3;

  // Record error codes.
  localparam logic [ErrW-1:0] ErrOk        = 3'd0;
  localparam logic [ErrW-1:0] ErrTooLong   = 3'd1;
  localparam logic [ErrW-1:0] ErrTruncated = 3'd2;
  localparam logic [ErrW-1:0] ErrOverrun   = 3'd3;
  localparam logic [ErrW-1:0] ErrOversize  = 3'd4;

  // Result queue between the parser and the output stage.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One queue entry: the first result of an item, plus a flag that an ok close follows.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag;
    logic [ValW-1:0]  raw;
    logic [7:0]       pbyte;
    logic             plast;
    logic [ErrW-1:0]  err;
    logic             two;
  } tvrp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tvrp_fifo_st_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag;
    logic [ValW-1:0]  raw;
    logic [ValW-1:0]  sgn;
    logic [7:0]       pbyte;
    logic             plast;
    logic [ErrW-1:0]  err;
    logic             last;
  } tvrp_result_t;

endpackage

`default_nettype wire

FILE: sv/tagged_varint_record_parser.sv
// Top level of the tagged varint record parser.
`timescale 1ns / 1ps
`default_nettype none
`include "tagged_varint_record_parser_defines.svh"

// Parses a length-prefixed record stream of varint keys, varint fields and bytes
// fields, one stream byte per item. The parser accepts one item every cycle as
// long as its four-entry result queue has room; an item that finishes a field on
// the last byte of its record yields two result items, its result and an ok
// close, which leave the output register one after the other, so the sustained
// rate is one item per cycle while m_axis_tready stays high, except where such
// pairs follow each other faster than the queue drains. The master-side tvalid
// of a result rises once its item has passed the result queue and the output
// register. An oversize length prefix halts the parser until a restart item
// (tuser high). The record length limit is written through cfg_we_i and
// cfg_wdata_i while the block is idle; no clearing pass is needed after reset.
module tagged_varint_record_parser import tvrp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // data_byte
  input  wire logic [0:0]           s_axis_tuser,   // op
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tag[30:0], value_raw[62:31], value_signed[94:63], payload_byte[102:95],
  // payload_last[103], error_code[106:104], zero fill[111:107]
  output logic [OutTdataW-1:0]      m_axis_tdata,
  output logic [KindW-1:0]          m_axis_tuser,   // kind
  output logic                      m_axis_tlast,   // last
  input  wire logic                 cfg_we_i,
  input  wire logic [LenW-1:0]      cfg_wdata_i     // record length limit
);

  logic          push, pop;
  tvrp_entry_t   wentry, rentry;
  tvrp_fifo_st_t fifo_st;
  tvrp_result_t  res;

  tvrp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser[0]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fifo_st_i     (fifo_st),
    .push_o        (push),
    .entry_o       (wentry)
  );

  tvrp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wentry),
    .pop_i    (pop),
    .rdata_o  (rentry),
    .status_o (fifo_st)
  );

  tvrp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (rentry),
    .fifo_st_i     (fifo_st),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {5'd0, res.err, res.plast, res.pbyte, res.sgn, res.raw, res.tag};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  `TVRP_ASSERT_NEVER(a_push_into_full, clk_i, rst_ni, push && fifo_st.full)
  `TVRP_ASSERT_NEVER(a_pop_from_empty, clk_i, rst_ni, pop && fifo_st.empty)
  `TVRP_ASSERT(a_close_is_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == KindClose) |-> m_axis_tlast)
  `TVRP_ASSERT(a_err_only_on_close, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != KindClose) |-> (res.err == ErrOk))

endmodule

`default_nettype wire

FILE: sv/tvrp_front.sv
// Parser front end: accepts stream items, runs the record state machine, queues results.
`timescale 1ns / 1ps
`default_nettype none

module tvrp_front import tvrp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InTdataW-1:0] s_axis_tdata,   // data_byte
  input  wire logic                s_axis_tuser,   // op
  input  wire logic                cfg_we_i,
  input  wire logic [LenW-1:0]     cfg_wdata_i,
  input  wire tvrp_fifo_st_t       fifo_st_i,
  output logic                     push_o,
  output tvrp_entry_t              entry_o
);

  localparam logic [2:0] PhLen     = 3'd0;
  localparam logic [2:0] PhKey     = 3'd1;
  localparam logic [2:0] PhVal     = 3'd2;
  localparam logic [2:0] PhBlen    = 3'd3;
  localparam logic [2:0] PhPay     = 3'd4;
  localparam logic [2:0] PhDiscard = 3'd5;
  localparam logic [2:0] PhHalt    = 3'd6;
  localparam logic [2:0] PhSpare   = 3'd7;

  logic [2:0]      phase_q, phase_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [LenW-1:0] rec_rem_q, rec_rem_d;
  logic [LenW-1:0] pay_rem_q, pay_rem_d;
  logic [TagW-1:0] cur_tag_q, cur_tag_d;
  logic [ErrW-1:0] rec_err_q, rec_err_d;
  logic [LenW-1:0] max_q, max_d;

  logic            accept;
  logic [7:0]      b;
  logic            in_len;
  logic [ValW-1:0] acc_base, acc_new;
  logic [2:0]      cnt_base;
  logic [3:0]      cnt_sum;
  logic [LenW-1:0] rr, pr;
  logic            rr_zero;
  logic            do_fail, do_bound;
  logic [ErrW-1:0] fail_err;

  // Bit offset of the next 7-bit group; a sixth group wraps onto the first.
  function automatic logic [4:0] grp_shift(input logic [2:0] c);
    logic [4:0] s;
    unique case (c)
      3'd0: s = 5'd0;
      3'd1: s = 5'd7;
      3'd2: s = 5'd14;
      3'd3: s = 5'd21;
      3'd4: s = 5'd28;
      3'd5: s = 5'd0;
      3'd6: s = 5'd7;
      3'd7: s = 5'd14;
    endcase
    return s;
  endfunction

  assign s_axis_tready = !fifo_st_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  assign in_len   = (phase_q == PhLen) || (phase_q == PhSpare) || (rec_rem_q == '0);
  assign acc_base = (in_len && phase_q != PhLen) ? '0 : acc_q;
  assign cnt_base = (in_len && phase_q != PhLen) ? '0 : cnt_q;
  assign acc_new  = acc_base | (ValW'({25'd0, b[6:0]}) << grp_shift(cnt_base));
  assign cnt_sum  = {1'b0, cnt_base} + 4'd1;
  assign rr       = rec_rem_q - LenW'(1);
  assign rr_zero  = (rr == '0);
  assign pr       = (pay_rem_q != '0) ? pay_rem_q - LenW'(1) : '0;

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    rec_rem_d = rec_rem_q;
    pay_rem_d = pay_rem_q;
    cur_tag_d = cur_tag_q;
    rec_err_d = rec_err_q;
    max_d     = cfg_we_i ? cfg_wdata_i : max_q;
    push_o    = 1'b0;
    entry_o   = '0;
    do_fail   = 1'b0;
    do_bound  = 1'b0;
    fail_err  = ErrOk;

    if (accept) begin
      if (s_axis_tuser) begin
        phase_d   = PhLen;
        acc_d     = '0;
        cnt_d     = '0;
        rec_rem_d = '0;
        pay_rem_d = '0;
        cur_tag_d = '0;
        rec_err_d = ErrOk;
      end else if (phase_q == PhHalt) begin
        phase_d = PhHalt;
      end else if (in_len) begin
        // Length prefix; the fifth byte ends it regardless of its continuation bit.
        phase_d = PhLen;
        acc_d   = acc_new;
        cnt_d   = cnt_sum[2:0];
        if (!b[7] || cnt_sum >= 4'(MaxGroups)) begin
          acc_d = '0;
          cnt_d = '0;
          if (acc_new > {5'd0, max_q}) begin
            push_o        = 1'b1;
            entry_o.kind  = KindClose;
            entry_o.err   = ErrOversize;
            phase_d       = PhHalt;
            rec_rem_d     = '0;
          end else if (acc_new == '0) begin
            push_o        = 1'b1;
            entry_o.kind  = KindClose;
            entry_o.err   = ErrOk;
            rec_err_d     = ErrOk;
            pay_rem_d     = '0;
          end else begin
            rec_rem_d = acc_new[LenW-1:0];
            phase_d   = PhKey;
          end
        end
      end else begin
        rec_rem_d = rr;
        unique case (phase_q)
          PhDiscard: begin
            if (rr_zero) begin
              push_o       = 1'b1;
              entry_o.kind = KindClose;
              entry_o.err  = rec_err_q;
              phase_d      = PhLen;
              acc_d        = '0;
              cnt_d        = '0;
              rec_err_d    = ErrOk;
              pay_rem_d    = '0;
            end
          end
          PhPay: begin
            pay_rem_d     = pr;
            push_o        = 1'b1;
            entry_o.kind  = KindPayload;
            entry_o.tag   = cur_tag_q;
            entry_o.pbyte = b;
            entry_o.plast = (pr == '0);
            do_bound      = (pr == '0);
          end
          default: begin
            // Key, varint value or bytes length.
            acc_d = acc_new;
            cnt_d = cnt_sum[2:0];
            if (b[7]) begin
              if (cnt_sum >= 4'(MaxGroups)) begin
                do_fail  = 1'b1;
                fail_err = ErrTooLong;
              end else if (rr_zero) begin
                do_fail  = 1'b1;
                fail_err = ErrTruncated;
              end
            end else begin
              acc_d = '0;
              cnt_d = '0;
              if (phase_q == PhKey) begin
                cur_tag_d = acc_new[ValW-1:1];
                if (rr_zero) begin
                  do_fail  = 1'b1;
                  fail_err = ErrTruncated;
                end else begin
                  phase_d = acc_new[0] ? PhBlen : PhVal;
                end
              end else if (phase_q == PhVal) begin
                push_o       = 1'b1;
                entry_o.kind = KindVarint;
                entry_o.tag  = cur_tag_q;
                entry_o.raw  = acc_new;
                do_bound     = 1'b1;
              end else if (acc_new > {5'd0, rr}) begin
                do_fail  = 1'b1;
                fail_err = ErrOverrun;
              end else begin
                push_o       = 1'b1;
                entry_o.kind = KindHeader;
                entry_o.tag  = cur_tag_q;
                entry_o.raw  = acc_new;
                if (acc_new == '0) begin
                  do_bound = 1'b1;
                end else begin
                  pay_rem_d = acc_new[LenW-1:0];
                  phase_d   = PhPay;
                end
              end
            end
          end
        endcase

        if (do_fail) begin
          acc_d = '0;
          cnt_d = '0;
          if (rr_zero) begin
            push_o       = 1'b1;
            entry_o.kind = KindClose;
            entry_o.err  = fail_err;
            phase_d      = PhLen;
            rec_err_d    = ErrOk;
            pay_rem_d    = '0;
          end else begin
            rec_err_d = fail_err;
            phase_d   = PhDiscard;
          end
        end

        // A field ending exactly at the record end adds an ok close after its result.
        if (do_bound) begin
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PhKey;
          if (rr_zero) begin
            entry_o.two = 1'b1;
            phase_d     = PhLen;
            rec_err_d   = ErrOk;
            pay_rem_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLen;
      acc_q     <= '0;
      cnt_q     <= '0;
      rec_rem_q <= '0;
      pay_rem_q <= '0;
      cur_tag_q <= '0;
      rec_err_q <= ErrOk;
      max_q     <= MaxRecordReset;
    end else begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      rec_rem_q <= rec_rem_d;
      pay_rem_q <= pay_rem_d;
      cur_tag_q <= cur_tag_d;
      rec_err_q <= rec_err_d;
      max_q     <= max_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tvrp_fifo.sv
// Short result queue that decouples the parser from the output stage.
`timescale 1ns / 1ps
`default_nettype none

module tvrp_fifo import tvrp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire tvrp_entry_t  wdata_i,
  input  wire logic         pop_i,
  output tvrp_entry_t       rdata_o,
  output tvrp_fifo_st_t     status_o
);

  tvrp_entry_t         mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, wptr_d;
  logic [FifoPtrW-1:0] rptr_q, rptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + FifoPtrW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + FifoPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + FifoCntW'(push_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tvrp_back.sv
// Output stage: expands queued entries into result items behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module tvrp_back import tvrp_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tvrp_entry_t   entry_i,
  input  wire tvrp_fifo_st_t fifo_st_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output tvrp_result_t       res_o
);

  tvrp_result_t res_q, res_d;
  logic         valid_q, valid_d;
  logic         pend_q, pend_d;

  assign pop_o         = !fifo_st_i.empty && (!valid_q || (m_axis_tready && !pend_q));
  assign m_axis_tvalid = valid_q;
  assign res_o         = res_q;

  always_comb begin
    res_d   = res_q;
    valid_d = valid_q;
    pend_d  = pend_q;

    if (valid_q && m_axis_tready) begin
      if (pend_q) begin
        res_d      = '0;
        res_d.kind = KindClose;
        res_d.err  = ErrOk;
        res_d.last = 1'b1;
        pend_d     = 1'b0;
      end else begin
        valid_d = 1'b0;
      end
    end

    if (pop_o) begin
      res_d.kind  = entry_i.kind;
      res_d.tag   = entry_i.tag;
      res_d.raw   = entry_i.raw;
      // Zigzag decoding only for varint fields.
      res_d.sgn   = (entry_i.kind == KindVarint) ?
                    ({1'b0, entry_i.raw[ValW-1:1]} ^ {ValW{entry_i.raw[0]}}) : '0;
      res_d.pbyte = entry_i.pbyte;
      res_d.plast = entry_i.plast;
      res_d.err   = entry_i.err;
      res_d.last  = !entry_i.two;
      valid_d     = 1'b1;
      pend_d      = entry_i.two;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire
